[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, switched off while rst_n is low.
`define SKRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define SKRL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/skrl_pkg.sv]
// ---------------------------------------------------------------------------
// skrl_pkg
// Types and constants of the sorted key range lookup block.
// ---------------------------------------------------------------------------
package skrl_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MAX_MATCHES_DEF = 64;

  localparam int KEY_W    = 64;
  localparam int MOVE_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int LEARN_W  = 32;
  localparam int PAY_W    = MOVE_W + WEIGHT_W + LEARN_W;
  localparam int DATA_W   = KEY_W + PAY_W;
  localparam int STATUS_W = 2;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SRCH_RD,
    BK_SRCH_CMP,
    BK_SCAN_RD,
    BK_SCAN_CHK
  } back_state_t;

  // command handed from front to back; payload = {move, weight, learn}
  typedef struct packed {
    cmd_kind_t          kind;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic               last;
  } res_t;

endpackage

[rtl/skrl_ram.sv]
// ---------------------------------------------------------------------------
// skrl_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module skrl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/skrl_front.sv]
// ---------------------------------------------------------------------------
// skrl_front
// Input stage: takes a word, splits its fields and classifies the command.
// ---------------------------------------------------------------------------
module skrl_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [skrl_pkg::DATA_W-1:0] in_tdata,
  input  logic                       in_tuser,
  output logic                       cmd_valid,
  output skrl_pkg::cmd_t             cmd,
  input  logic                       cmd_ready
);

  logic           valid_r, valid_nxt;
  skrl_pkg::cmd_t cmd_r, cmd_nxt;

  assign in_tready = !valid_r || cmd_ready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (valid_r && cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      valid_nxt       = 1'b1;
      cmd_nxt.kind    = in_tuser ? skrl_pkg::CMD_LOOKUP : skrl_pkg::CMD_APPEND;
      cmd_nxt.key     = in_tdata[skrl_pkg::KEY_W-1:0];
      // tdata above the key holds move, weight, learn from low to high
      cmd_nxt.payload = {in_tdata[skrl_pkg::KEY_W+skrl_pkg::MOVE_W-1:skrl_pkg::KEY_W],
                         in_tdata[skrl_pkg::KEY_W+skrl_pkg::MOVE_W+skrl_pkg::WEIGHT_W-1:
                                  skrl_pkg::KEY_W+skrl_pkg::MOVE_W],
                         in_tdata[skrl_pkg::DATA_W-1:
                                  skrl_pkg::KEY_W+skrl_pkg::MOVE_W+skrl_pkg::WEIGHT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

[rtl/skrl_queue.sv]
// ---------------------------------------------------------------------------
// skrl_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module skrl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  skrl_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output skrl_pkg::cmd_t pop_cmd
);

  skrl_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/skrl_back.sv]
// ---------------------------------------------------------------------------
// skrl_back
// Table owner: appends records, runs the lower-bound search and the scan
// over equal keys, and holds the output register.
// ---------------------------------------------------------------------------
module skrl_back #(
  parameter int TABLE_DEPTH = skrl_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_MATCHES = skrl_pkg::MAX_MATCHES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  skrl_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  output skrl_pkg::res_t res,
  input  logic           res_ready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(MAX_MATCHES + 1);

  skrl_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              lo_r, lo_nxt;
  logic [CW-1:0]              hi_r, hi_nxt;
  logic [CW-1:0]              mid_r, mid_nxt;
  logic [NW-1:0]              n_r, n_nxt;
  logic [skrl_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                       in_range_r, in_range_nxt;
  logic                       pend_r, pend_nxt;
  logic [skrl_pkg::KEY_W-1:0] pend_key_r, pend_key_nxt;
  logic [skrl_pkg::PAY_W-1:0] pend_pay_r, pend_pay_nxt;
  logic                       out_valid_r, out_valid_nxt;
  skrl_pkg::res_t             out_r, out_nxt;

  logic [CW-1:0]              span;
  logic [CW-1:0]              mid;
  logic                       out_free;
  logic                       hit;
  logic                       at_max;
  logic                       last_pend;

  logic                       ram_we;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [skrl_pkg::KEY_W-1:0] rd_key;
  logic [skrl_pkg::PAY_W-1:0] rd_pay;

  skrl_ram #(.WIDTH(skrl_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (cmd.key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_key)
  );

  skrl_ram #(.WIDTH(skrl_pkg::PAY_W), .DEPTH(TABLE_DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (cmd.payload),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_pay)
  );

  assign span      = hi_r - lo_r;
  assign mid       = lo_r + (span >> 1);
  assign out_free  = !out_valid_r || res_ready;
  assign hit       = in_range_r && (rd_key == key_r);
  assign at_max    = (n_r == NW'(MAX_MATCHES));
  assign last_pend = !hit || at_max;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    in_range_nxt  = in_range_r;
    pend_nxt      = pend_r;
    pend_key_nxt  = pend_key_r;
    pend_pay_nxt  = pend_pay_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = lo_r[AW-1:0];

    if (out_valid_r && res_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      skrl_pkg::BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.kind == skrl_pkg::CMD_APPEND) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.last  = 1'b1;
            if (count_r == CW'(TABLE_DEPTH)) begin
              out_nxt.status = skrl_pkg::ST_FULL;
            end else begin
              out_nxt.status = skrl_pkg::ST_OK;
              ram_we         = 1'b1;
              count_nxt      = count_r + 1'b1;
            end
          end else begin
            key_nxt   = cmd.key;
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = skrl_pkg::BK_SRCH_RD;
          end
        end
      end

      skrl_pkg::BK_SRCH_RD: begin
        if (lo_r < hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = skrl_pkg::BK_SRCH_CMP;
        end else begin
          // lo_r is the lower bound; start the scan there
          n_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = skrl_pkg::BK_SCAN_RD;
        end
      end

      skrl_pkg::BK_SRCH_CMP: begin
        if (rd_key < key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = skrl_pkg::BK_SRCH_RD;
      end

      skrl_pkg::BK_SCAN_RD: begin
        in_range_nxt = (lo_r < count_r);
        ram_re       = (lo_r < count_r);
        state_nxt    = skrl_pkg::BK_SCAN_CHK;
      end

      skrl_pkg::BK_SCAN_CHK: begin
        if (out_free) begin
          if (pend_r) begin
            // emit the held match now that we know whether another follows
            out_valid_nxt  = 1'b1;
            out_nxt.key    = pend_key_r;
            out_nxt.payload = pend_pay_r;
            out_nxt.last   = last_pend;
            out_nxt.status = (hit && at_max) ? skrl_pkg::ST_TRUNC : skrl_pkg::ST_OK;
          end else if (!hit) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.status = skrl_pkg::ST_NO_MATCH;
            out_nxt.last  = 1'b1;
          end
          if (!hit || (pend_r && at_max)) begin
            pend_nxt  = 1'b0;
            state_nxt = skrl_pkg::BK_IDLE;
          end else begin
            pend_nxt     = 1'b1;
            pend_key_nxt = rd_key;
            pend_pay_nxt = rd_pay;
            n_nxt        = n_r + 1'b1;
            lo_nxt       = lo_r + 1'b1;
            state_nxt    = skrl_pkg::BK_SCAN_RD;
          end
        end
      end

      default: begin
        state_nxt = skrl_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skrl_pkg::BK_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    n_r        <= n_nxt;
    key_r      <= key_nxt;
    in_range_r <= in_range_nxt;
    pend_key_r <= pend_key_nxt;
    pend_pay_r <= pend_pay_nxt;
    out_r      <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

[rtl/sorted_key_range_lookup.sv]
// ---------------------------------------------------------------------------
// sorted_key_range_lookup
// Append-only record table with binary-search lookup of equal key ranges.
// ---------------------------------------------------------------------------
// Words on the input stream either append a record (tuser 0) or look up a
// key (tuser 1). An append gives one word back: status ok, or table full
// when TABLE_DEPTH records are already stored (the record is then dropped).
// A lookup searches for the lower bound of its key, then returns every
// record with an equal key in table order, tlast on the final one; with no
// match it returns one no-match word, and past MAX_MATCHES it stops and
// marks the final word truncated. Records are expected in ascending key
// order; nothing checks this. The table is two single-port-read RAMs (key
// and payload) sharing one read address, and that one read port sets the
// pace: an append writes both RAMs as its command is taken; a lookup
// takes its command, halves the search range by reading the middle key
// and comparing it until the lower bound is found, closes the search,
// then reads and checks one record at a time (each returned match and the
// first record after the run); a stall on the result stream holds it.
// The RAMs need no clearing after reset; only entries below the record
// count are ever read. A front stage and a two-word command queue keep the
// input flowing while a lookup is busy, and the result sits in an output
// register, so either side may stall freely.
// ---------------------------------------------------------------------------
module sorted_key_range_lookup #(
  parameter int TABLE_DEPTH = skrl_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_MATCHES = skrl_pkg::MAX_MATCHES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [skrl_pkg::DATA_W-1:0]   in_tdata,   // key, move_word, weight, learn_word
  input  logic                          in_tuser,   // operation
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [skrl_pkg::DATA_W-1:0]   out_tdata,  // found_key, found_move, found_weight,
                                                    // found_learn
  output logic [skrl_pkg::STATUS_W-1:0] out_tuser,  // status
  output logic                          out_tlast
);

  logic           fr_valid;
  logic           fr_ready;
  skrl_pkg::cmd_t fr_cmd;
  logic           q_valid;
  logic           q_pop;
  skrl_pkg::cmd_t q_cmd;
  logic           res_valid;
  skrl_pkg::res_t res;

  skrl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd),
    .cmd_ready (fr_ready)
  );

  skrl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  skrl_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_MATCHES (MAX_MATCHES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_tready)
  );

  // payload is {move, weight, learn}; tdata wants key, move, weight, learn low to high
  assign out_tvalid = res_valid;
  assign out_tuser  = res.status;
  assign out_tlast  = res.last;
  assign out_tdata  = {res.payload[skrl_pkg::LEARN_W-1:0],
                       res.payload[skrl_pkg::LEARN_W+skrl_pkg::WEIGHT_W-1:skrl_pkg::LEARN_W],
                       res.payload[skrl_pkg::PAY_W-1:skrl_pkg::LEARN_W+skrl_pkg::WEIGHT_W],
                       res.key};

endmodule

[rtl/skrl_checker.sv]
// ---------------------------------------------------------------------------
// skrl_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module skrl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [skrl_pkg::DATA_W-1:0]   out_tdata,
  input logic [skrl_pkg::STATUS_W-1:0] out_tuser,
  input logic                          out_tlast
);

  logic                                         out_stall;
  logic [skrl_pkg::DATA_W+skrl_pkg::STATUS_W:0] out_word;
  logic                                         out_zero;
  logic                                         st_ok;
  logic                                         st_trunc;
  logic                                         st_empty;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tlast, out_tuser, out_tdata};
  assign out_zero  = (out_tdata == '0);
  assign st_ok     = (out_tuser == skrl_pkg::ST_OK);
  assign st_trunc  = (out_tuser == skrl_pkg::ST_TRUNC);
  assign st_empty  = (out_tuser == skrl_pkg::ST_NO_MATCH) || (out_tuser == skrl_pkg::ST_FULL);

  // a stalled word holds
  `SKRL_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled word changed")

  // nothing comes out straight after reset
  `SKRL_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

  // no match and table full are single, empty words
  `SKRL_ASSERT(a_empty_word, out_tvalid && st_empty |-> out_tlast && out_zero, "bad empty word")

  // truncation is only flagged on the final word
  `SKRL_ASSERT(a_trunc_last, out_tvalid && st_trunc |-> out_tlast, "truncated word not final")

  // words before the final one are plain matches
  `SKRL_ASSERT(a_mid_ok, out_tvalid && !out_tlast |-> st_ok, "non-final word not ok")

endmodule

bind sorted_key_range_lookup skrl_checker u_skrl_checker (.*);
